// ===== rtl/core/fk7_pkg.sv =====
// shared constants, types and helpers for the seven-joint forward kinematics block
`default_nettype none
package fk7_pkg;

  // field widths
  localparam int ANG_W = 16;
  localparam int OFF_W = 15;
  localparam int OUT_W = 16;

  // internal widths: Q28 values
  localparam int IFRAC   = 28;
  localparam int ENT_W   = 32;
  localparam int POS_W   = 34;
  localparam int TRIG_W  = 32;

  // parameter defaults
  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // cordic setup
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_X0    = 652032874;
  localparam int CORDIC_ATAN [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  // link twist kinds
  localparam int TW_ZERO = 0;
  localparam int TW_NEG  = 1;
  localparam int TW_POS  = 2;

  // pipeline timing
  localparam int NUM_LINKS  = 7;
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int LINK_LAT   = 2;
  localparam int LATENCY    = CORDIC_LAT + NUM_LINKS * LINK_LAT + 1;

  // register indexes and reset values
  typedef enum logic [1:0] {
    CFG_UPPER_ARM = 2'd0,
    CFG_FOREARM   = 2'd1,
    CFG_TOOL      = 2'd2
  } cfg_idx_t;

  localparam logic [OFF_W-1:0] UPPER_ARM_RST = 15'd7373;
  localparam logic [OFF_W-1:0] FOREARM_RST   = 15'd7864;
  localparam logic [OFF_W-1:0] TOOL_RST      = 15'd2949;

  // round half up by sh bits, then clamp to a 16-bit signed field
  function automatic logic signed [OUT_W-1:0] rnd_sat(input logic signed [35:0] v,
                                                      input int sh);
    logic signed [35:0] t;
    t = (v + (36'sd1 <<< (sh - 1))) >>> sh;
    if (t > 36'sd32767) begin
      rnd_sat = 16'sh7fff;
    end else if (t < -36'sd32768) begin
      rnd_sat = 16'sh8000;
    end else begin
      rnd_sat = t[OUT_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fk7_cordic.sv =====
// pipelined cordic giving cos and sin in Q28 of one binary angle
`default_nettype none
module fk7_cordic #(
  parameter int ANGLE_BITS = fk7_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic signed [fk7_pkg::ANG_W-1:0]  angle,
  output logic signed [fk7_pkg::TRIG_W-1:0]      cos_q,
  output logic signed [fk7_pkg::TRIG_W-1:0]      sin_q
);
  localparam int STEPS = fk7_pkg::CORDIC_STEPS;
  localparam logic signed [33:0] QUARTER = 34'sd1073741824;
  localparam logic signed [33:0] HALF    = 34'sd2147483648;

  logic signed [33:0] z_r   [STEPS+1];
  logic signed [32:0] x_r   [STEPS+1];
  logic signed [32:0] y_r   [STEPS+1];
  logic               neg_r [STEPS+1];

  logic [31:0]        phase;
  logic signed [33:0] z_raw;
  logic signed [33:0] z_adj;
  logic               neg;
  logic signed [32:0] x_fin;
  logic signed [32:0] y_fin;

  // phase in turns scaled to 2^32, folded into the right half plane
  always_comb begin
    phase = 32'(32'($signed(angle)) << (32 - ANGLE_BITS));
    z_raw = 34'($signed(phase));
    z_adj = z_raw;
    neg   = 1'b0;
    if (z_raw > QUARTER) begin
      z_adj = z_raw - HALF;
      neg   = 1'b1;
    end else if (z_raw < -QUARTER) begin
      z_adj = z_raw + HALF;
      neg   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    z_r[0]   <= z_adj;
    x_r[0]   <= 33'(fk7_pkg::CORDIC_X0);
    y_r[0]   <= '0;
    neg_r[0] <= neg;
  end

  // one rotation step per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [33:0] AT = 34'(fk7_pkg::CORDIC_ATAN[i]);
    always_ff @(posedge clk) begin
      neg_r[i+1] <= neg_r[i];
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - AT;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + AT;
      end
    end
  end

  // undo the fold and round Q30 to Q28
  always_comb begin
    x_fin = neg_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
    y_fin = neg_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
  end

  always_ff @(posedge clk) begin
    cos_q <= 32'((x_fin + 33'sd2) >>> 2);
    sin_q <= 32'((y_fin + 33'sd2) >>> 2);
  end

endmodule
`default_nettype wire

// ===== rtl/core/fk7_link.sv =====
// one link of the chain: rotation and position update over two stages
`default_nettype none
module fk7_link #(
  parameter int TWIST     = fk7_pkg::TW_ZERO,
  parameter bit HAS_OFF   = 1'b0,
  parameter int FRAC_BITS = fk7_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic signed [fk7_pkg::ENT_W-1:0]   rot_i [3][3],
  input  wire logic signed [fk7_pkg::POS_W-1:0]   pos_i [3],
  input  wire logic signed [fk7_pkg::TRIG_W-1:0]  cq,
  input  wire logic signed [fk7_pkg::TRIG_W-1:0]  sq,
  input  wire logic        [fk7_pkg::OFF_W-1:0]   off,
  output logic signed [fk7_pkg::ENT_W-1:0]        rot_o [3][3],
  output logic signed [fk7_pkg::POS_W-1:0]        pos_o [3]
);
  localparam logic signed [64:0] HALF_R = 65'sd1 <<< (fk7_pkg::IFRAC - 1);
  localparam logic signed [48:0] HALF_P = 49'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0] pac_r [3];
  logic signed [63:0] pbs_r [3];
  logic signed [63:0] pbc_r [3];
  logic signed [63:0] pas_r [3];
  logic signed [31:0] n2_r  [3];
  logic signed [47:0] pp_r  [3];
  logic signed [33:0] pos_r [3];

  logic signed [31:0] b_sel [3];
  logic signed [31:0] n2    [3];
  logic signed [31:0] pm    [3];
  logic signed [47:0] pp    [3];

  // pick the column mixed in by the twist, and the column that passes through
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (TWIST == fk7_pkg::TW_ZERO) begin
        b_sel[r] = rot_i[r][1];
        n2[r]    = rot_i[r][2];
      end else if (TWIST == fk7_pkg::TW_POS) begin
        b_sel[r] = rot_i[r][2];
        n2[r]    = -rot_i[r][1];
      end else begin
        b_sel[r] = -rot_i[r][2];
        n2[r]    = rot_i[r][1];
      end
      pm[r] = -rot_i[r][1];
      pp[r] = $signed({1'b0, off}) * pm[r];
    end
  end

  // stage one: products
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      pac_r[r] <= rot_i[r][0] * cq;
      pbs_r[r] <= b_sel[r] * sq;
      pbc_r[r] <= b_sel[r] * cq;
      pas_r[r] <= rot_i[r][0] * sq;
      n2_r[r]  <= n2[r];
      pp_r[r]  <= pp[r];
      pos_r[r] <= pos_i[r];
    end
  end

  // stage two: sums with rounding
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      rot_o[r][0] <= 32'((65'(pac_r[r]) + 65'(pbs_r[r]) + HALF_R) >>> fk7_pkg::IFRAC);
      rot_o[r][1] <= 32'((65'(pbc_r[r]) - 65'(pas_r[r]) + HALF_R) >>> fk7_pkg::IFRAC);
      rot_o[r][2] <= n2_r[r];
      if (HAS_OFF) begin
        pos_o[r] <= pos_r[r] + 34'((49'(pp_r[r]) + HALF_P) >>> FRAC_BITS);
      end else begin
        pos_o[r] <= pos_r[r];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/seven_joint_forward_kinematics_top.sv =====
// top level of the seven-joint forward kinematics pipeline
//
//  port group      direction  handshake           content
//  in_*            input      start / busy        seven joint angles
//  out_*           output     out_valid strobe    rotation matrix and position
//  cfg_*           input      cfg_we              three link offsets
//
// one item enters per cycle; busy stays low
// each taken item passes through the cordic pipelines, the product and sum stages
// of each of the seven links, and the output rounding stage
// reset clears the valid pipe and loads the default offsets
// results are shown for one cycle only and cannot be held off
`default_nettype none
module seven_joint_forward_kinematics_top #(
  parameter int ANGLE_BITS = fk7_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = fk7_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [fk7_pkg::ANG_W-1:0]   in_joint1_angle,
  input  wire logic signed [fk7_pkg::ANG_W-1:0]   in_joint2_angle,
  input  wire logic signed [fk7_pkg::ANG_W-1:0]   in_joint3_angle,
  input  wire logic signed [fk7_pkg::ANG_W-1:0]   in_joint4_angle,
  input  wire logic signed [fk7_pkg::ANG_W-1:0]   in_joint5_angle,
  input  wire logic signed [fk7_pkg::ANG_W-1:0]   in_joint6_angle,
  input  wire logic signed [fk7_pkg::ANG_W-1:0]   in_joint7_angle,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [fk7_pkg::OFF_W-1:0]          cfg_data,
  output logic                                    out_valid,
  output logic signed [fk7_pkg::OUT_W-1:0]        out_rot_xx,
  output logic signed [fk7_pkg::OUT_W-1:0]        out_rot_xy,
  output logic signed [fk7_pkg::OUT_W-1:0]        out_rot_xz,
  output logic signed [fk7_pkg::OUT_W-1:0]        out_rot_yx,
  output logic signed [fk7_pkg::OUT_W-1:0]        out_rot_yy,
  output logic signed [fk7_pkg::OUT_W-1:0]        out_rot_yz,
  output logic signed [fk7_pkg::OUT_W-1:0]        out_rot_zx,
  output logic signed [fk7_pkg::OUT_W-1:0]        out_rot_zy,
  output logic signed [fk7_pkg::OUT_W-1:0]        out_rot_zz,
  output logic signed [fk7_pkg::OUT_W-1:0]        out_pos_x,
  output logic signed [fk7_pkg::OUT_W-1:0]        out_pos_y,
  output logic signed [fk7_pkg::OUT_W-1:0]        out_pos_z
);
  localparam int LAT = fk7_pkg::LATENCY;
  localparam int NL  = fk7_pkg::NUM_LINKS;
  localparam int SH  = fk7_pkg::IFRAC - FRAC_BITS;
  localparam logic signed [fk7_pkg::ENT_W-1:0] ONE = 32'sd1 <<< fk7_pkg::IFRAC;

  logic [fk7_pkg::OFF_W-1:0] upper_r;
  logic [fk7_pkg::OFF_W-1:0] fore_r;
  logic [fk7_pkg::OFF_W-1:0] tool_r;
  logic [LAT-1:0]            vld_r;

  logic signed [fk7_pkg::ANG_W-1:0]  ang   [NL];
  logic signed [fk7_pkg::TRIG_W-1:0] cq    [NL];
  logic signed [fk7_pkg::TRIG_W-1:0] sq    [NL];
  logic signed [fk7_pkg::TRIG_W-1:0] cq_l  [NL];
  logic signed [fk7_pkg::TRIG_W-1:0] sq_l  [NL];
  logic [fk7_pkg::OFF_W-1:0]         off_s [NL];
  logic signed [fk7_pkg::ENT_W-1:0]  rot_s [NL+1][3][3];
  logic signed [fk7_pkg::POS_W-1:0]  pos_s [NL+1][3];

  logic signed [fk7_pkg::OUT_W-1:0]  rot_out_r [3][3];
  logic signed [fk7_pkg::OUT_W-1:0]  pos_out_r [3];

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= fk7_pkg::UPPER_ARM_RST;
      fore_r  <= fk7_pkg::FOREARM_RST;
      tool_r  <= fk7_pkg::TOOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fk7_pkg::CFG_UPPER_ARM: upper_r <= cfg_data;
        fk7_pkg::CFG_FOREARM:   fore_r  <= cfg_data;
        fk7_pkg::CFG_TOOL:      tool_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits follow each item down the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  assign ang[0] = in_joint1_angle;
  assign ang[1] = in_joint2_angle;
  assign ang[2] = in_joint3_angle;
  assign ang[3] = in_joint4_angle;
  assign ang[4] = in_joint5_angle;
  assign ang[5] = in_joint6_angle;
  assign ang[6] = in_joint7_angle;

  // chain starts from identity at the origin
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rot_s[0][r][c] = (r == c) ? ONE : '0;
      end
      pos_s[0][r] = '0;
    end
  end

  for (genvar k = 0; k < NL; k++) begin : g_joint
    // sine and cosine of this joint
    fk7_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clk   (clk),
      .angle (ang[k]),
      .cos_q (cq[k]),
      .sin_q (sq[k])
    );

    // hold trig values until the chain reaches this link
    if (k == 0) begin : g_nodly
      assign cq_l[k] = cq[k];
      assign sq_l[k] = sq[k];
    end else begin : g_dly
      logic signed [fk7_pkg::TRIG_W-1:0] cd_r [2*k];
      logic signed [fk7_pkg::TRIG_W-1:0] sd_r [2*k];
      always_ff @(posedge clk) begin
        cd_r[0] <= cq[k];
        sd_r[0] <= sq[k];
        for (int j = 1; j < 2 * k; j++) begin
          cd_r[j] <= cd_r[j-1];
          sd_r[j] <= sd_r[j-1];
        end
      end
      assign cq_l[k] = cd_r[2*k-1];
      assign sq_l[k] = sd_r[2*k-1];
    end

    assign off_s[k] = (k == 2) ? upper_r : (k == 4) ? fore_r : (k == 6) ? tool_r : '0;

    fk7_link #(
      .TWIST     ((k == 0) ? fk7_pkg::TW_ZERO :
                  ((k % 2) == 1) ? fk7_pkg::TW_NEG : fk7_pkg::TW_POS),
      .HAS_OFF   ((k == 2) || (k == 4) || (k == 6)),
      .FRAC_BITS (FRAC_BITS)
    ) u_link (
      .clk   (clk),
      .rot_i (rot_s[k]),
      .pos_i (pos_s[k]),
      .cq    (cq_l[k]),
      .sq    (sq_l[k]),
      .off   (off_s[k]),
      .rot_o (rot_s[k+1]),
      .pos_o (pos_s[k+1])
    );
  end

  // output rounding and saturation
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rot_out_r[r][c] <= fk7_pkg::rnd_sat(36'(rot_s[NL][r][c]), SH);
      end
      pos_out_r[r] <= fk7_pkg::rnd_sat(36'(pos_s[NL][r]), SH);
    end
  end

  assign out_valid  = vld_r[LAT-1];
  assign out_rot_xx = rot_out_r[0][0];
  assign out_rot_xy = rot_out_r[0][1];
  assign out_rot_xz = rot_out_r[0][2];
  assign out_rot_yx = rot_out_r[1][0];
  assign out_rot_yy = rot_out_r[1][1];
  assign out_rot_yz = rot_out_r[1][2];
  assign out_rot_zx = rot_out_r[2][0];
  assign out_rot_zy = rot_out_r[2][1];
  assign out_rot_zz = rot_out_r[2][2];
  assign out_pos_x  = pos_out_r[0];
  assign out_pos_y  = pos_out_r[1];
  assign out_pos_z  = pos_out_r[2];

endmodule
`default_nettype wire

// ===== rtl/core/fk7_checker.sv =====
// port-level checks of item timing for the kinematics top, bound to it
`default_nettype none
module fk7_sva (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);
  localparam int LAT = fk7_pkg::LATENCY;

  // the pipeline never refuses an item
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every taken item gives a result after the fixed latency
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LAT) out_valid)
    else $error("result missing for taken item");

  // no result without an item taken the fixed latency earlier
  a_out_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without item");

endmodule

bind seven_joint_forward_kinematics_top fk7_sva u_fk7_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
`default_nettype wire

// ===== verif/fk7_checker.sv =====
// pose predictor and result checker for the seven-joint forward kinematics block
`default_nettype none
module fk7_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic                                busy,
  input  wire logic [6:0][fk7_pkg::ANG_W-1:0]      angles,
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [fk7_pkg::OFF_W-1:0]           cfg_data,
  input  wire logic                                out_valid,
  input  wire logic [11:0][fk7_pkg::OUT_W-1:0]     pose,
  output int                                       pending,
  output int                                       fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [11:0][fk7_pkg::OUT_W-1:0] pose_t;

  localparam int LINK_TWIST [fk7_pkg::NUM_LINKS] = '{fk7_pkg::TW_ZERO, fk7_pkg::TW_NEG,
                                                     fk7_pkg::TW_POS, fk7_pkg::TW_NEG,
                                                     fk7_pkg::TW_POS, fk7_pkg::TW_NEG,
                                                     fk7_pkg::TW_POS};
  localparam string FIELD_NAME [12] = '{"rot_xx", "rot_xy", "rot_xz", "rot_yx", "rot_yy",
                                        "rot_yz", "rot_zx", "rot_zy", "rot_zz", "pos_x",
                                        "pos_y", "pos_z"};

  logic [fk7_pkg::OFF_W-1:0] upper_arm_d, forearm_d, tool_d;
  pose_t                     pose_q [$];

  function automatic longint rnd_shift(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic [fk7_pkg::OUT_W-1:0] clamp16(input longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[fk7_pkg::OUT_W-1:0];
  endfunction

  // cordic sine and cosine of a binary angle, Q28
  function automatic void joint_trig(input logic [fk7_pkg::ANG_W-1:0] a, output longint c,
                                     output longint s);
    longint z, x, y, dx, dy;
    logic   flip;
    z = longint'(int'({a, 16'h0000}));
    flip = 1'b0;
    if (z > 64'sd1073741824) begin
      z = z - 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z = z + 64'sd2147483648;
      flip = 1'b1;
    end
    x = fk7_pkg::CORDIC_X0;
    y = 0;
    for (int i = 0; i < fk7_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - fk7_pkg::CORDIC_ATAN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + fk7_pkg::CORDIC_ATAN[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = rnd_shift(x, 2);
    s = rnd_shift(y, 2);
  endfunction

  // chain the seven link transforms and round to the output format
  function automatic pose_t predict_pose(input logic [6:0][fk7_pkg::ANG_W-1:0] ang);
    longint one, cq, sq, acc, col;
    longint rot [3][3];
    longint lk [3][3];
    longint nr [3][3];
    longint p [3];
    longint d;
    int     ca, sa;
    pose_t  res;
    one = 64'sd1 <<< fk7_pkg::IFRAC;
    for (int r = 0; r < 3; r++) begin
      p[r] = 0;
      for (int c = 0; c < 3; c++) rot[r][c] = (r == c) ? one : 0;
    end
    for (int l = 0; l < fk7_pkg::NUM_LINKS; l++) begin
      ca = (LINK_TWIST[l] == fk7_pkg::TW_ZERO) ? 1 : 0;
      sa = (LINK_TWIST[l] == fk7_pkg::TW_NEG) ? -1 : (LINK_TWIST[l] == fk7_pkg::TW_POS) ? 1 : 0;
      case (l)
        2:       d = longint'(upper_arm_d) <<< (fk7_pkg::IFRAC - fk7_pkg::FRAC_BITS_DEF);
        4:       d = longint'(forearm_d) <<< (fk7_pkg::IFRAC - fk7_pkg::FRAC_BITS_DEF);
        6:       d = longint'(tool_d) <<< (fk7_pkg::IFRAC - fk7_pkg::FRAC_BITS_DEF);
        default: d = 0;
      endcase
      joint_trig(ang[l], cq, sq);
      lk[0][0] = cq;      lk[0][1] = -sq;     lk[0][2] = 0;
      lk[1][0] = sq * ca; lk[1][1] = cq * ca; lk[1][2] = -sa * one;
      lk[2][0] = sq * sa; lk[2][1] = cq * sa; lk[2][2] = ca * one;
      // offset moves along the column that the twist selects, before the rotation
      for (int r = 0; r < 3; r++) begin
        col = (ca != 0) ? rot[r][2] * ca : -rot[r][1] * sa;
        p[r] = p[r] + rnd_shift(d * col, fk7_pkg::IFRAC);
      end
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc = acc + rot[r][k] * lk[k][c];
          nr[r][c] = rnd_shift(acc, fk7_pkg::IFRAC);
        end
      rot = nr;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++)
        res[r*3 + c] = clamp16(rnd_shift(rot[r][c], fk7_pkg::IFRAC - fk7_pkg::FRAC_BITS_DEF));
      res[9 + r] = clamp16(rnd_shift(p[r], fk7_pkg::IFRAC - fk7_pkg::FRAC_BITS_DEF));
    end
    return res;
  endfunction

  assign pending = pose_q.size();

  // offsets, accepted items and results, all sampled at the rising edge
  always @(posedge clk) begin
    pose_t want;
    if (!rst_n) begin
      upper_arm_d <= fk7_pkg::UPPER_ARM_RST;
      forearm_d   <= fk7_pkg::FOREARM_RST;
      tool_d      <= fk7_pkg::TOOL_RST;
    end else begin
      if (cfg_we) begin
        unique case (fk7_pkg::cfg_idx_t'(cfg_index))
          fk7_pkg::CFG_UPPER_ARM: upper_arm_d <= cfg_data;
          fk7_pkg::CFG_FOREARM:   forearm_d <= cfg_data;
          fk7_pkg::CFG_TOOL:      tool_d <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) pose_q.push_back(predict_pose(angles));
      if (out_valid) begin
        if (pose_q.size() == 0) begin
          $error("result with no item waiting");
          fail_count++;
        end else begin
          want = pose_q.pop_front();
          for (int f = 0; f < 12; f++)
            if (pose[f] !== want[f]) begin
              $error("%s: expected %0d, got %0d", FIELD_NAME[f],
                     $signed(want[f]), $signed(pose[f]));
              fail_count++;
            end
        end
      end
    end
  end

  initial fail_count = 0;
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// stimulus and verdict for the seven-joint forward kinematics block
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [6:0][fk7_pkg::ANG_W-1:0] ang = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [fk7_pkg::OFF_W-1:0] cfg_data = '0;
  logic out_valid;
  logic [11:0][fk7_pkg::OUT_W-1:0] pose;
  int pending, fail_count, idle_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  seven_joint_forward_kinematics_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_joint1_angle(ang[0]), .in_joint2_angle(ang[1]), .in_joint3_angle(ang[2]),
    .in_joint4_angle(ang[3]), .in_joint5_angle(ang[4]), .in_joint6_angle(ang[5]),
    .in_joint7_angle(ang[6]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_rot_xx(pose[0]), .out_rot_xy(pose[1]), .out_rot_xz(pose[2]),
    .out_rot_yx(pose[3]), .out_rot_yy(pose[4]), .out_rot_yz(pose[5]),
    .out_rot_zx(pose[6]), .out_rot_zy(pose[7]), .out_rot_zz(pose[8]),
    .out_pos_x(pose[9]), .out_pos_y(pose[10]), .out_pos_z(pose[11])
  );

  fk7_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .angles(ang),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .pose(pose), .pending(pending), .fail_count(fail_count)
  );

  // watchdog on cycles with nothing accepted and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** seven_joint_forward_kinematics_top: FAILED **");
        $finish;
      end
    end
  end

  // present one item at a falling edge and hold it until taken
  task automatic send_item(input logic [6:0][fk7_pkg::ANG_W-1:0] a);
    start = 1'b1;
    ang = a;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic pause(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // let every result drain before touching the offsets
  task automatic drain;
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (fk7_pkg::LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_offset(input logic [1:0] idx, input logic [fk7_pkg::OFF_W-1:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_offsets(input logic [fk7_pkg::OFF_W-1:0] u,
                             input logic [fk7_pkg::OFF_W-1:0] f,
                             input logic [fk7_pkg::OFF_W-1:0] t);
    write_offset(fk7_pkg::CFG_UPPER_ARM, u);
    write_offset(fk7_pkg::CFG_FOREARM, f);
    write_offset(fk7_pkg::CFG_TOOL, t);
  endtask

  // mostly uniform angles, some near the eighth-turn boundaries
  function automatic logic [fk7_pkg::ANG_W-1:0] rand_angle;
    logic [fk7_pkg::ANG_W-1:0] a;
    if ($urandom_range(3) == 0) begin
      a = 16'($urandom_range(7) * 8192) + 16'($urandom_range(4)) - 16'd2;
    end else begin
      a = 16'($urandom);
    end
    return a;
  endfunction

  // bursts of random length with random gaps, some stretches without gaps
  task automatic random_burst_run(input int count);
    logic [6:0][fk7_pkg::ANG_W-1:0] a;
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(2) != 0) pause($urandom_range(1, 12));
      end
      for (int j = 0; j < 7; j++) a[j] = rand_angle();
      send_item(a);
      burst--;
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed items at reset offsets
    send_item('0);
    send_item({7{16'h7fff}});
    send_item({7{16'h8000}});
    send_item({7{16'h4000}});
    send_item({7{16'hc000}});
    send_item({7{16'h2000}});
    send_item({7{16'h0001}});
    send_item({7{16'hffff}});
    send_item({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555});
    send_item({16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa});
    send_item({16'h4001, 16'h3fff, 16'hc001, 16'hbfff, 16'h8001, 16'h7ffe, 16'h0000});
    pause(3);
    send_item({16'h0000, 16'h4000, 16'h0000, 16'hc000, 16'h0000, 16'h4000, 16'h0000});
    send_item({16'h1234, 16'hedcb, 16'h0800, 16'hf800, 16'h6000, 16'ha000, 16'h3000});

    // largest offsets, with a stretched arm to push the position to saturation
    drain();
    set_offsets(15'h7fff, 15'h7fff, 15'h7fff);
    write_offset(2'd3, 15'h1234);
    send_item('0);
    send_item({7{16'h8000}});
    send_item({16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h0000});
    send_item({16'h2000, 16'h4000, 16'h0000, 16'h4000, 16'h0000, 16'hc000, 16'h0000});
    random_burst_run(230);

    // zero offsets
    drain();
    set_offsets('0, '0, '0);
    send_item({7{16'h7fff}});
    random_burst_run(230);

    // random offsets
    drain();
    set_offsets(15'($urandom), 15'($urandom), 15'($urandom));
    random_burst_run(230);

    // back to the default lengths
    drain();
    set_offsets(fk7_pkg::UPPER_ARM_RST, fk7_pkg::FOREARM_RST, fk7_pkg::TOOL_RST);
    random_burst_run(200);

    // wait for everything to come back, then one more random phase
    drain();
    set_offsets(15'($urandom), 15'd1, 15'h7ffe);
    random_burst_run(230);

    drain();
    if (fail_count == 0) begin
      $display("** seven_joint_forward_kinematics_top: PASSED **");
    end else begin
      $display("** seven_joint_forward_kinematics_top: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/fk7_pkg.sv
rtl/core/fk7_cordic.sv
rtl/core/fk7_link.sv
rtl/core/seven_joint_forward_kinematics_top.sv
rtl/core/fk7_checker.sv
verif/fk7_checker.sv
verif/tb_top.sv
